@@ sv/lsrlg_pkg.sv @@
// ----------------------------------------------------------------------------
// LED strip run-length grouper package
// Buffer geometry, command codes and the command and result transaction types.
// ----------------------------------------------------------------------------
package lsrlg_pkg;

  localparam int LED_COUNT    = 64;
  localparam int DEFAULT_LEDS = 8;
  localparam int IDX_W        = $clog2(LED_COUNT);
  localparam int LEN_W        = $clog2(LED_COUNT + 1);
  localparam int CH_W         = 8;
  localparam int COLOUR_W     = 4 * CH_W;

  localparam logic [LED_COUNT-1:0] DEFAULT_MASK =
    {LED_COUNT{1'b1}} >> (LED_COUNT - DEFAULT_LEDS);

  localparam logic [1:0] CMD_SET   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_DRAIN = 2'd2;

  typedef struct packed {
    logic [1:0]      command;
    logic [5:0]      run_start;
    logic [6:0]      run_length;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
    logic [CH_W-1:0] in_white;
  } cmd_t;

  typedef struct packed {
    logic            changed;
    logic            has_group;
    logic [5:0]      group_start;
    logic [6:0]      group_length;
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_white;
    logic            last;
  } res_t;

endpackage

@@ sv/led_strip_run_length_grouper.sv @@
// ----------------------------------------------------------------------------
// LED strip run-length grouper
// Keeps a 64-entry RGBW buffer, writes colour runs into it and reads it out
// as one transaction per run of equal-coloured present entries.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  command   in         start high, busy low       cmd_i   (cmd_t)
//  result    out        res_strobe_o, one cycle    res_o   (res_t)
//
//  Set: writes min(run_length, 64 - run_start) entries, one buffer write a cycle.
//  Readout with the flag set: one entry a cycle through the
//  colour memory's single read port and one shared 32-bit colour compare.
//  Readout with the flag clear and drain: handled in the idle state, busy stays low.
//  Reset restores the default buffer at once; no clearing pass is needed.
//  The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module led_strip_run_length_grouper import lsrlg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  cmd_t cmd_i,
  output logic busy,
  output logic res_strobe_o,
  output res_t res_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_SET, ST_READ, ST_FINISH} state_e;

  state_e                 state_q;
  logic [LEN_W-1:0]       idx_q;
  logic [LEN_W-1:0]       rem_q;
  logic [COLOUR_W-1:0]    colour_q;
  logic [LED_COUNT-1:0]   present_q;
  logic [LED_COUNT-1:0]   dflt_q;
  logic                   changed_q;

  logic [COLOUR_W-1:0]    colour_mem_q [LED_COUNT];
  logic [COLOUR_W-1:0]    rdata_q;

  logic                   p_vld_q;
  logic [IDX_W-1:0]       p_idx_q;
  logic                   p_pres_q;
  logic                   p_dflt_q;

  logic                   open_q;
  logic [IDX_W-1:0]       g_start_q;
  logic [LEN_W-1:0]       g_len_q;
  logic [COLOUR_W-1:0]    g_colour_q;

  logic                   pend_vld_q;
  res_t                   pend_q;
  res_t                   res_q;
  logic                   res_strobe_q;

  logic                   idx_in_range;
  logic                   mem_we;
  logic                   mem_re;
  logic [COLOUR_W-1:0]    entry_colour;
  logic                   colour_eq;
  logic                   close_grp;
  logic                   start_grp;
  logic                   extend_grp;
  res_t                   group_res;
  res_t                   final_res;
  res_t                   idle_res;

  assign idx_in_range = idx_q < LEN_W'(LED_COUNT);
  assign mem_we       = (state_q == ST_SET) && (rem_q != '0) && idx_in_range;
  assign mem_re       = (state_q == ST_READ) && idx_in_range;
  assign entry_colour = p_dflt_q ? {COLOUR_W{1'b1}} : rdata_q;
  assign colour_eq    = entry_colour == g_colour_q;

  always_comb begin
    close_grp  = 1'b0;
    start_grp  = 1'b0;
    extend_grp = 1'b0;
    if (state_q == ST_FINISH) begin
      close_grp = open_q;
    end else if (state_q == ST_READ && p_vld_q) begin
      close_grp  = open_q && (!p_pres_q || !colour_eq);
      start_grp  = p_pres_q && !(open_q && colour_eq);
      extend_grp = p_pres_q && open_q && colour_eq;
    end
  end

  always_comb begin
    group_res              = '0;
    group_res.changed      = 1'b1;
    group_res.has_group    = 1'b1;
    group_res.group_start  = g_start_q;
    group_res.group_length = g_len_q;
    group_res.out_red      = g_colour_q[4*CH_W-1:3*CH_W];
    group_res.out_green    = g_colour_q[3*CH_W-1:2*CH_W];
    group_res.out_blue     = g_colour_q[2*CH_W-1:CH_W];
    group_res.out_white    = g_colour_q[CH_W-1:0];

    if (pend_vld_q) begin
      final_res = pend_q;
    end else begin
      final_res         = '0;
      final_res.changed = 1'b1;
    end
    final_res.last = 1'b1;

    idle_res      = '0;
    idle_res.last = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      colour_mem_q[idx_q[IDX_W-1:0]] <= colour_q;
    end
    if (mem_re) begin
      rdata_q <= colour_mem_q[idx_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      rem_q        <= '0;
      colour_q     <= '0;
      present_q    <= DEFAULT_MASK;
      dflt_q       <= DEFAULT_MASK;
      changed_q    <= 1'b0;
      p_vld_q      <= 1'b0;
      p_idx_q      <= '0;
      p_pres_q     <= 1'b0;
      p_dflt_q     <= 1'b0;
      open_q       <= 1'b0;
      g_start_q    <= '0;
      g_len_q      <= '0;
      g_colour_q   <= '0;
      pend_vld_q   <= 1'b0;
      pend_q       <= '0;
      res_q        <= '0;
      res_strobe_q <= 1'b0;
    end else begin
      res_strobe_q <= 1'b0;

      if (close_grp) begin
        if (pend_vld_q) begin
          res_q        <= pend_q;
          res_strobe_q <= 1'b1;
        end
        pend_q     <= group_res;
        pend_vld_q <= 1'b1;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            unique case (cmd_i.command)
              CMD_SET: begin
                idx_q     <= LEN_W'(cmd_i.run_start);
                rem_q     <= cmd_i.run_length;
                colour_q  <= {cmd_i.in_red, cmd_i.in_green, cmd_i.in_blue, cmd_i.in_white};
                changed_q <= 1'b1;
                state_q   <= ST_SET;
              end
              CMD_READ: begin
                if (changed_q) begin
                  idx_q      <= '0;
                  p_vld_q    <= 1'b0;
                  open_q     <= 1'b0;
                  pend_vld_q <= 1'b0;
                  state_q    <= ST_READ;
                end else begin
                  res_q        <= idle_res;
                  res_strobe_q <= 1'b1;
                end
              end
              CMD_DRAIN: begin
                present_q <= '0;
                dflt_q    <= '0;
              end
              default: begin
              end
            endcase
          end
        end

        ST_SET: begin
          if (mem_we) begin
            present_q[idx_q[IDX_W-1:0]] <= 1'b1;
            dflt_q[idx_q[IDX_W-1:0]]    <= 1'b0;
            idx_q                       <= idx_q + LEN_W'(1);
            rem_q                       <= rem_q - LEN_W'(1);
          end else begin
            state_q <= ST_IDLE;
          end
        end

        ST_READ: begin
          if (idx_in_range) begin
            p_vld_q  <= 1'b1;
            p_idx_q  <= idx_q[IDX_W-1:0];
            p_pres_q <= present_q[idx_q[IDX_W-1:0]];
            p_dflt_q <= dflt_q[idx_q[IDX_W-1:0]];
            idx_q    <= idx_q + LEN_W'(1);
          end else begin
            p_vld_q <= 1'b0;
          end

          if (p_vld_q) begin
            if (start_grp) begin
              open_q     <= 1'b1;
              g_start_q  <= p_idx_q;
              g_len_q    <= LEN_W'(1);
              g_colour_q <= entry_colour;
            end else if (extend_grp) begin
              g_len_q <= g_len_q + LEN_W'(1);
            end else if (!p_pres_q) begin
              open_q <= 1'b0;
            end
          end else if (!idx_in_range) begin
            state_q <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          if (open_q) begin
            open_q <= 1'b0;
          end else begin
            res_q        <= final_res;
            res_strobe_q <= 1'b1;
            present_q    <= '0;
            dflt_q       <= '0;
            changed_q    <= 1'b0;
            pend_vld_q   <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign busy         = state_q != ST_IDLE;
  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

endmodule

@@ sv/lsrlg_checker.sv @@
// ----------------------------------------------------------------------------
// LED strip run-length grouper port checker
// Watches the command and result transactions on the top-level ports.
// ----------------------------------------------------------------------------
module lsrlg_checker import lsrlg_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input cmd_t cmd_i,
  input logic busy,
  input logic res_strobe_o,
  input res_t res_o
);

  a_mid_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !res_o.last |-> busy)
    else $error("non-final result outside a readout walk");

  a_unchanged_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !res_o.changed |-> res_o.last && !res_o.has_group)
    else $error("unchanged readout must be a single empty result");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !res_o.has_group |-> res_o.last)
    else $error("result without a group must end the readout");

  a_group_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && res_o.has_group |-> res_o.group_length != '0)
    else $error("group result with zero length");

  a_set_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && cmd_i.command == CMD_SET |=> busy)
    else $error("set transaction did not start the write walk");

endmodule

bind led_strip_run_length_grouper lsrlg_checker u_lsrlg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .cmd_i        (cmd_i),
  .busy         (busy),
  .res_strobe_o (res_strobe_o),
  .res_o        (res_o)
);
